/* rtl/core/polygon_plane_clip_defines.svh */
// Assertion macros for the polygon plane clipper checker.
`ifndef POLYGON_PLANE_CLIP_DEFINES_SVH
`define POLYGON_PLANE_CLIP_DEFINES_SVH

// Checked only while out of reset.
`define PPC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define PPC_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/ppc_pkg.sv */
// Types, widths and codes shared by the polygon plane clipper.
package ppc_pkg;

    localparam int COORD_BITS    = 32;
    localparam int FRAC_BITS     = 16;
    localparam int NORM_BITS     = 16;
    localparam int NORM_FRAC     = 14;
    localparam int OFFS_BITS     = 32;
    localparam int TOL_BITS      = 31;
    localparam int CFG_DATA_BITS = 32;
    localparam int CFG_IDX_BITS  = 3;

    localparam int PROD_BITS  = COORD_BITS + NORM_BITS;
    localparam int TERM_BITS  = PROD_BITS - NORM_FRAC;
    localparam int S_BITS     = ((TERM_BITS > OFFS_BITS) ? TERM_BITS : OFFS_BITS) + 3;
    localparam int MAG_BITS   = S_BITS;
    localparam int DEN_BITS   = S_BITS + 1;
    localparam int REM_BITS   = S_BITS + 2;
    localparam int DIFF_BITS  = COORD_BITS + 1;
    localparam int LPROD_BITS = DIFF_BITS + FRAC_BITS;
    localparam int SUM_BITS   = COORD_BITS + 2;
    localparam int DCNT_BITS  = $clog2(FRAC_BITS + 1);

    localparam logic signed [NORM_BITS-1:0] NORMAL_Z_RESET = NORM_BITS'(16384);
    localparam logic [TOL_BITS-1:0]         TOL_RESET      = TOL_BITS'(66);

    localparam logic [CFG_IDX_BITS-1:0] REG_NORMAL_X    = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_NORMAL_Y    = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_NORMAL_Z    = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_PLANE_OFFS  = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_SIDE_TOL    = 3'd4;

    typedef enum logic [1:0] {SIDE_ON = 2'd0, SIDE_FRONT = 2'd1, SIDE_BACK = 2'd2} t_side;
    typedef enum logic [1:0] {AX_X, AX_Y, AX_Z} t_axis;
    typedef enum logic [1:0] {PSEL_CUR, PSEL_PREV, PSEL_FIRST} t_psel;
    typedef enum logic [1:0] {ACC_HOLD, ACC_INIT, ACC_ADD} t_acc;
    typedef enum logic [1:0] {DST_NONE, DST_CLASS, DST_SA, DST_SB} t_dst;
    typedef enum logic [1:0] {EM_VERT, EM_CROSS, EM_NULL} t_emit;

    typedef enum logic [3:0] {
        S_IDLE, S_M0, S_M1, S_M2, S_M3, S_SAVE, S_PLAN, S_NEXT,
        S_DIVS, S_DIVW, S_LM, S_LF, S_EMIT, S_DONE
    } t_state;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] vertex_x;
        logic signed [COORD_BITS-1:0] vertex_y;
        logic signed [COORD_BITS-1:0] vertex_z;
        logic                         final_vertex;
    } t_in;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] out_x;
        logic signed [COORD_BITS-1:0] out_y;
        logic signed [COORD_BITS-1:0] out_z;
        logic                         point_valid;
        logic                         polygon_end;
    } t_out;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] z;
    } t_vec;

    typedef struct packed {
        logic  load_cur;
        logic  mul_en;
        t_axis axis;
        t_psel psel;
        t_acc  acc_op;
        t_dst  dst;
        logic  set_first;
        logic  shift_prev;
        logic  div_start;
        logic  lerp_mul;
        logic  lerp_fin;
        t_axis lerp_axis;
        logic  e_sel;
        logic  emit;
        t_emit emit_kind;
        logic  emit_end;
    } t_cmd;

    typedef struct packed {
        t_side cur_side;
        t_side prev_side;
        t_side first_side;
        logic  cur_last;
        logic  div_busy;
        logic  out_free;
    } t_stat;

endpackage

/* rtl/core/ppc_ctrl.sv */
// Sequencer for the polygon plane clipper: classify, plan and run each edge.
module ppc_ctrl import ppc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state     r_state, n_state;
    logic       r_have_prev, n_have_prev;
    logic [4:0] r_todo, n_todo;
    logic [4:0] r_bit, n_bit;
    t_dst       r_dst, n_dst;
    logic       r_esel, n_esel;
    t_axis      r_ax, n_ax;
    t_emit      r_kind, n_kind;

    logic       cross0, cross1, keep0, keep1;
    logic [4:0] rest;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_have_prev <= 1'b0;
            r_todo      <= '0;
            r_bit       <= '0;
            r_dst       <= DST_NONE;
            r_esel      <= 1'b0;
            r_ax        <= AX_X;
            r_kind      <= EM_VERT;
        end else begin
            r_state     <= n_state;
            r_have_prev <= n_have_prev;
            r_todo      <= n_todo;
            r_bit       <= n_bit;
            r_dst       <= n_dst;
            r_esel      <= n_esel;
            r_ax        <= n_ax;
            r_kind      <= n_kind;
        end
    end

    // strict front/back crossings only
    assign cross0 = (i_stat.prev_side == SIDE_FRONT && i_stat.cur_side == SIDE_BACK) ||
                    (i_stat.prev_side == SIDE_BACK && i_stat.cur_side == SIDE_FRONT);
    assign cross1 = (i_stat.cur_side == SIDE_FRONT && i_stat.first_side == SIDE_BACK) ||
                    (i_stat.cur_side == SIDE_BACK && i_stat.first_side == SIDE_FRONT);
    assign keep0  = i_stat.prev_side != SIDE_FRONT;
    assign keep1  = i_stat.cur_side != SIDE_FRONT;
    assign rest   = r_todo & ~r_bit;

    always_comb begin
        n_state     = r_state;
        n_have_prev = r_have_prev;
        n_todo      = r_todo;
        n_bit       = r_bit;
        n_dst       = r_dst;
        n_esel      = r_esel;
        n_ax        = r_ax;
        n_kind      = r_kind;
        o_in_ready  = 1'b0;
        o_cmd       = '0;
        o_cmd.e_sel = r_esel;
        o_cmd.dst   = DST_NONE;
        o_cmd.lerp_axis = r_ax;
        o_cmd.emit_kind = r_kind;
        unique case (r_dst)
            DST_SA:  o_cmd.psel = r_esel ? PSEL_CUR : PSEL_PREV;
            DST_SB:  o_cmd.psel = r_esel ? PSEL_FIRST : PSEL_CUR;
            default: o_cmd.psel = PSEL_CUR;
        endcase

        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_cur = 1'b1;
                    n_dst   = DST_CLASS;
                    n_state = S_M0;
                end
            end
            S_M0: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.axis   = AX_X;
                n_state      = S_M1;
            end
            S_M1: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.axis   = AX_Y;
                o_cmd.acc_op = ACC_INIT;
                n_state      = S_M2;
            end
            S_M2: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.axis   = AX_Z;
                o_cmd.acc_op = ACC_ADD;
                n_state      = S_M3;
            end
            S_M3: begin
                o_cmd.acc_op = ACC_ADD;
                n_state      = S_SAVE;
            end
            S_SAVE: begin
                o_cmd.dst = r_dst;
                unique case (r_dst)
                    DST_CLASS: begin
                        o_cmd.set_first = !r_have_prev;
                        n_state = S_PLAN;
                    end
                    DST_SA: begin
                        n_dst   = DST_SB;
                        n_state = S_M0;
                    end
                    default: n_state = S_DIVS;
                endcase
            end
            S_PLAN: begin
                n_todo[0] = r_have_prev && keep0;
                n_todo[1] = r_have_prev && cross0;
                n_todo[2] = i_stat.cur_last && keep1;
                n_todo[3] = i_stat.cur_last && cross1;
                n_todo[4] = i_stat.cur_last && !(r_have_prev && keep0) &&
                            !(r_have_prev && cross0) && !keep1 && !cross1;
                n_state   = S_NEXT;
            end
            S_NEXT: begin
                if (r_todo[0]) begin
                    n_bit = 5'b00001; n_esel = 1'b0; n_kind = EM_VERT; n_state = S_EMIT;
                end else if (r_todo[1]) begin
                    n_bit = 5'b00010; n_esel = 1'b0; n_kind = EM_CROSS;
                    n_dst = DST_SA; n_state = S_M0;
                end else if (r_todo[2]) begin
                    n_bit = 5'b00100; n_esel = 1'b1; n_kind = EM_VERT; n_state = S_EMIT;
                end else if (r_todo[3]) begin
                    n_bit = 5'b01000; n_esel = 1'b1; n_kind = EM_CROSS;
                    n_dst = DST_SA; n_state = S_M0;
                end else if (r_todo[4]) begin
                    n_bit = 5'b10000; n_kind = EM_NULL; n_state = S_EMIT;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DIVS: begin
                o_cmd.div_start = 1'b1;
                n_state = S_DIVW;
            end
            S_DIVW: begin
                if (!i_stat.div_busy) begin
                    n_ax    = AX_X;
                    n_state = S_LM;
                end
            end
            S_LM: begin
                o_cmd.lerp_mul = 1'b1;
                n_state = S_LF;
            end
            S_LF: begin
                o_cmd.lerp_fin = 1'b1;
                unique case (r_ax)
                    AX_X:    begin n_ax = AX_Y; n_state = S_LM; end
                    AX_Y:    begin n_ax = AX_Z; n_state = S_LM; end
                    default: n_state = S_EMIT;
                endcase
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.emit_end = i_stat.cur_last && (rest == '0);
                    n_todo  = rest;
                    n_state = S_NEXT;
                end
            end
            S_DONE: begin
                o_cmd.shift_prev = 1'b1;
                n_have_prev = !i_stat.cur_last;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

/* rtl/core/ppc_dpath.sv */
// Datapath: plane registers, vertex store, distance MAC, divider, lerp, output register.
module ppc_dpath import ppc_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cmd                     i_cmd,
    output t_stat                    o_stat,
    input  t_in                      i_in,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    input  logic                     i_out_ready,
    output logic                     o_out_valid,
    output t_out                     o_out
);

    function automatic logic signed [COORD_BITS-1:0] pick(input t_vec v, input t_axis a);
        logic signed [COORD_BITS-1:0] r;
        case (a)
            AX_X:    r = v.x;
            AX_Y:    r = v.y;
            default: r = v.z;
        endcase
        return r;
    endfunction

    function automatic logic [MAG_BITS-1:0] mag(input logic signed [S_BITS-1:0] v);
        return (v < 0) ? MAG_BITS'(-v) : MAG_BITS'(v);
    endfunction

    logic signed [NORM_BITS-1:0]  r_nx, r_ny, r_nz;
    logic signed [OFFS_BITS-1:0]  r_offs;
    logic [TOL_BITS-1:0]          r_tol;

    t_vec  r_cur, r_prev, r_first, r_cross;
    t_side r_cur_side, r_prev_side, r_first_side;
    logic  r_last;

    logic signed [PROD_BITS-1:0] r_prod;
    logic signed [S_BITS-1:0]    r_acc, r_sa, r_sb;

    logic [REM_BITS-1:0]  r_rem;
    logic [DEN_BITS-1:0]  r_den;
    logic [FRAC_BITS-1:0] r_t;
    logic [DCNT_BITS-1:0] r_cnt;
    logic                 r_div_busy;

    logic [LPROD_BITS-1:0] r_lprod;
    logic                  r_lneg;

    logic r_out_valid;
    t_out r_out;

    t_vec                        pt, a_v, b_v;
    logic signed [COORD_BITS-1:0] coord_m, ca, cb, sat_v;
    logic signed [NORM_BITS-1:0]  norm_m;
    logic signed [PROD_BITS-1:0]  prod_n;
    logic signed [S_BITS-1:0]     term, tol_ext, offs_ext;
    t_side                        cls;
    logic [REM_BITS-1:0]          rem2;
    logic                         ge;
    logic signed [DIFF_BITS-1:0]  diff;
    logic [DIFF_BITS-1:0]         dmag, off;
    logic [LPROD_BITS-1:0]        lprod_n;
    logic signed [SUM_BITS-1:0]   sum;
    logic                         out_free;

    always_comb begin
        case (i_cmd.psel)
            PSEL_PREV:  pt = r_prev;
            PSEL_FIRST: pt = r_first;
            default:    pt = r_cur;
        endcase
        case (i_cmd.axis)
            AX_X:    norm_m = r_nx;
            AX_Y:    norm_m = r_ny;
            default: norm_m = r_nz;
        endcase
    end

    assign coord_m  = pick(pt, i_cmd.axis);
    assign prod_n   = PROD_BITS'(norm_m) * PROD_BITS'(coord_m);
    assign term     = S_BITS'(r_prod >>> NORM_FRAC);
    assign offs_ext = S_BITS'(r_offs);
    assign tol_ext  = S_BITS'($signed({1'b0, r_tol}));

    always_comb begin
        if (r_acc > tol_ext)       cls = SIDE_FRONT;
        else if (r_acc < -tol_ext) cls = SIDE_BACK;
        else                       cls = SIDE_ON;
    end

    // restoring divider, one quotient bit a cycle
    assign rem2 = {r_rem[REM_BITS-2:0], 1'b0};
    assign ge   = rem2 >= REM_BITS'(r_den);

    assign a_v     = i_cmd.e_sel ? r_cur : r_prev;
    assign b_v     = i_cmd.e_sel ? r_first : r_cur;
    assign ca      = pick(a_v, i_cmd.lerp_axis);
    assign cb      = pick(b_v, i_cmd.lerp_axis);
    assign diff    = DIFF_BITS'(cb) - DIFF_BITS'(ca);
    assign dmag    = (diff < 0) ? DIFF_BITS'(-diff) : DIFF_BITS'(diff);
    assign lprod_n = LPROD_BITS'(dmag) * LPROD_BITS'(r_t);
    assign off     = r_lprod[LPROD_BITS-1:FRAC_BITS];
    assign sum     = r_lneg ? SUM_BITS'(ca) - SUM_BITS'($signed({1'b0, off}))
                            : SUM_BITS'(ca) + SUM_BITS'($signed({1'b0, off}));

    always_comb begin
        if (sum[SUM_BITS-1:COORD_BITS-1] == '0 || sum[SUM_BITS-1:COORD_BITS-1] == '1)
            sat_v = sum[COORD_BITS-1:0];
        else if (sum[SUM_BITS-1])
            sat_v = {1'b1, {(COORD_BITS-1){1'b0}}};
        else
            sat_v = {1'b0, {(COORD_BITS-1){1'b1}}};
    end

    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nx         <= '0;
            r_ny         <= '0;
            r_nz         <= NORMAL_Z_RESET;
            r_offs       <= '0;
            r_tol        <= TOL_RESET;
            r_cur_side   <= SIDE_ON;
            r_prev_side  <= SIDE_ON;
            r_first_side <= SIDE_ON;
            r_last       <= 1'b0;
            r_div_busy   <= 1'b0;
            r_cnt        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_NORMAL_X:   r_nx   <= i_cfg_data[NORM_BITS-1:0];
                    REG_NORMAL_Y:   r_ny   <= i_cfg_data[NORM_BITS-1:0];
                    REG_NORMAL_Z:   r_nz   <= i_cfg_data[NORM_BITS-1:0];
                    REG_PLANE_OFFS: r_offs <= i_cfg_data[OFFS_BITS-1:0];
                    REG_SIDE_TOL:   r_tol  <= i_cfg_data[TOL_BITS-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.load_cur) r_last <= i_in.final_vertex;
            if (i_cmd.dst == DST_CLASS) begin
                r_cur_side <= cls;
                if (i_cmd.set_first) r_first_side <= cls;
            end
            if (i_cmd.shift_prev) r_prev_side <= r_cur_side;
            if (i_cmd.div_start) begin
                r_div_busy <= 1'b1;
                r_cnt      <= DCNT_BITS'(FRAC_BITS);
            end else if (r_div_busy) begin
                r_cnt      <= r_cnt - DCNT_BITS'(1);
                r_div_busy <= r_cnt != DCNT_BITS'(1);
            end
            if (i_cmd.emit)          r_out_valid <= 1'b1;
            else if (i_out_ready)    r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_cur) begin
            r_cur <= '{x: i_in.vertex_x, y: i_in.vertex_y, z: i_in.vertex_z};
        end
        if (i_cmd.dst == DST_CLASS && i_cmd.set_first) r_first <= r_cur;
        if (i_cmd.shift_prev) r_prev <= r_cur;
        if (i_cmd.mul_en) r_prod <= prod_n;
        case (i_cmd.acc_op)
            ACC_INIT: r_acc <= term - offs_ext;
            ACC_ADD:  r_acc <= r_acc + term;
            default:  ;
        endcase
        if (i_cmd.dst == DST_SA) r_sa <= r_acc;
        if (i_cmd.dst == DST_SB) r_sb <= r_acc;
        if (i_cmd.div_start) begin
            r_rem <= REM_BITS'(mag(r_sa));
            r_den <= DEN_BITS'(mag(r_sa)) + DEN_BITS'(mag(r_sb));
            r_t   <= '0;
        end else if (r_div_busy && r_den != '0) begin
            r_rem <= ge ? rem2 - REM_BITS'(r_den) : rem2;
            r_t   <= {r_t[FRAC_BITS-2:0], ge};
        end
        if (i_cmd.lerp_mul) begin
            r_lprod <= lprod_n;
            r_lneg  <= diff < 0;
        end
        if (i_cmd.lerp_fin) begin
            case (i_cmd.lerp_axis)
                AX_X:    r_cross.x <= sat_v;
                AX_Y:    r_cross.y <= sat_v;
                default: r_cross.z <= sat_v;
            endcase
        end
        if (i_cmd.emit) begin
            r_out.polygon_end <= i_cmd.emit_end;
            case (i_cmd.emit_kind)
                EM_VERT: begin
                    r_out.out_x <= a_v.x; r_out.out_y <= a_v.y; r_out.out_z <= a_v.z;
                    r_out.point_valid <= 1'b1;
                end
                EM_CROSS: begin
                    r_out.out_x <= r_cross.x; r_out.out_y <= r_cross.y;
                    r_out.out_z <= r_cross.z;
                    r_out.point_valid <= 1'b1;
                end
                default: begin
                    r_out.out_x <= '0; r_out.out_y <= '0; r_out.out_z <= '0;
                    r_out.point_valid <= 1'b0;
                end
            endcase
        end
    end

    always_comb begin
        o_stat.cur_side   = r_cur_side;
        o_stat.prev_side  = r_prev_side;
        o_stat.first_side = r_first_side;
        o_stat.cur_last   = r_last;
        o_stat.div_busy   = r_div_busy;
        o_stat.out_free   = out_free;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

/* rtl/core/polygon_plane_clip.sv */
// Top level of the single-plane polygon clipper (back side kept).
//
//  channel  | direction | handshake               | item
//  ---------+-----------+-------------------------+-----------------------------
//  in       | input     | i_in_valid / o_in_ready | one vertex, final marker
//  out      | output    | o_out_valid/i_out_ready | one clipped vertex or marker
//  cfg      | input     | i_cfg_we (no wait)      | plane normal, offset, tol
//
// A vertex is classified by a MAC on one shared multiplier (states M0 to M3),
// then save and plan. Each kept vertex or empty marker then costs a pick and
// an emit; a front/back crossing costs a pick, two distance passes, the serial
// divider, the three lerp multiplies and the emit. A final pick and wrap-up
// follow before the next vertex is taken.
// Reset is synchronous, active low; plane registers return to z-up, offset 0.
// A result waits in the output register; the sequencer stalls there only when
// a second result is ready before the first is taken.
module polygon_plane_clip import ppc_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  t_in                      i_in,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output t_out                     o_out,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    // command and status between sequencer and datapath
    t_cmd  cmd;
    t_stat stat;

    ppc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    ppc_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_in        (i_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

endmodule

/* rtl/core/ppc_checker.sv */
// Port-level checker for the polygon plane clipper, bound to the top level.
`include "polygon_plane_clip_defines.svh"

module ppc_checker import ppc_pkg::*; (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_in_valid,
    input logic                     o_in_ready,
    input t_in                      i_in,
    input logic                     o_out_valid,
    input logic                     i_out_ready,
    input t_out                     o_out,
    input logic                     i_cfg_we,
    input logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    `PPC_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid, "result dropped while stalled")
    `PPC_ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> !o_out_valid, "result present after reset")
    `PPC_ASSERT(a_one_item, i_clk, i_rst_n, i_in_valid && o_in_ready |=> !o_in_ready, "item taken while busy")
    `PPC_ASSERT(a_marker_end, i_clk, i_rst_n, o_out_valid && !o_out.point_valid |-> o_out.polygon_end, "empty marker not end")

endmodule

bind polygon_plane_clip ppc_checker u_ppc_checker (.*);

/* test/polygon_plane_clip_tb.sv */
// Testbench for the single-plane polygon clipper: directed and random polygons, scoreboarded.
module polygon_plane_clip_tb import ppc_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    // Scoreboard: holds the plane setting and the ring state, predicts the
    // clipped vertices for each accepted vertex and checks results in order.
    class clip_scoreboard;
        logic signed [15:0] nx, ny, nz;
        logic signed [31:0] offs;
        logic [30:0]        tol;
        logic signed [63:0] fx, fy, fz, px, py, pz;
        t_side              fside, pside;
        bit                 have_prev;
        t_out               pending[$];
        int                 errors;

        function new();
            nx = 0; ny = 0; nz = 16384; offs = 0; tol = 66;
            fx = 0; fy = 0; fz = 0; px = 0; py = 0; pz = 0;
            fside = SIDE_ON; pside = SIDE_ON; have_prev = 0; errors = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] val);
            case (idx)
                REG_NORMAL_X:   nx = val[15:0];
                REG_NORMAL_Y:   ny = val[15:0];
                REG_NORMAL_Z:   nz = val[15:0];
                REG_PLANE_OFFS: offs = val;
                REG_SIDE_TOL:   tol = val[30:0];
                default: ;
            endcase
        endfunction

        function logic signed [63:0] plane_dist(logic signed [63:0] x, y, z);
            logic signed [63:0] s;
            // arithmetic shift gives the floor division by 2^14
            s = (64'(nx) * x) >>> 14;
            s += (64'(ny) * y) >>> 14;
            s += (64'(nz) * z) >>> 14;
            return s - 64'(offs);
        endfunction

        function t_side side_of(logic signed [63:0] x, y, z);
            logic signed [63:0] s, t;
            s = plane_dist(x, y, z);
            t = {33'd0, tol};
            if (s > t) return SIDE_FRONT;
            if (s < -t) return SIDE_BACK;
            return SIDE_ON;
        endfunction

        function logic signed [63:0] interp(logic signed [63:0] a, b, logic [63:0] t);
            logic signed [63:0] d, r;
            logic [63:0] m, off;
            d = b - a;
            m = (d < 0) ? -d : d;
            off = (m >> 16) * t + (((m & 64'hFFFF) * t) >> 16);
            r = (d < 0) ? a - $signed(off) : a + $signed(off);
            if (r > 64'sh7FFFFFFF) r = 64'sh7FFFFFFF;
            if (r < -64'sh80000000) r = -64'sh80000000;
            return r;
        endfunction

        function void push_point(logic signed [63:0] x, y, z, bit ok);
            t_out o;
            o.out_x = x[31:0]; o.out_y = y[31:0]; o.out_z = z[31:0];
            o.point_valid = ok; o.polygon_end = 0;
            pending = {pending, o};
        endfunction

        function void clip_edge(logic signed [63:0] ax, ay, az, t_side sa,
                                logic signed [63:0] bx, by, bz, t_side sb);
            logic signed [63:0] da, db;
            logic [63:0] na, den, r, t;
            if (sa != SIDE_FRONT) push_point(ax, ay, az, 1);
            if ((sa == SIDE_FRONT && sb == SIDE_BACK) || (sa == SIDE_BACK && sb == SIDE_FRONT)) begin
                da = plane_dist(ax, ay, az);
                db = plane_dist(bx, by, bz);
                na = (da < 0) ? -da : da;
                den = na + ((db < 0) ? -db : db);
                r = na; t = 0;
                if (den != 0) begin
                    for (int i = 0; i < FRAC_BITS; i++) begin
                        r = r << 1; t = t << 1;
                        if (r >= den) begin
                            r -= den; t |= 1;
                        end
                    end
                end
                push_point(interp(ax, bx, t), interp(ay, by, t), interp(az, bz, t), 1);
            end
        endfunction

        // Called for each accepted vertex.
        function void note_vertex(t_in v);
            logic signed [63:0] cx, cy, cz;
            t_side cs;
            int n0;
            n0 = pending.size();
            cx = 64'(v.vertex_x); cy = 64'(v.vertex_y); cz = 64'(v.vertex_z);
            cs = side_of(cx, cy, cz);
            if (!have_prev) begin
                fx = cx; fy = cy; fz = cz; fside = cs;
            end else begin
                clip_edge(px, py, pz, pside, cx, cy, cz, cs);
            end
            px = cx; py = cy; pz = cz; pside = cs;
            if (v.final_vertex) begin
                clip_edge(cx, cy, cz, cs, fx, fy, fz, fside);
                if (pending.size() == n0) push_point(0, 0, 0, 0);
                pending[$].polygon_end = 1;
                have_prev = 0;
            end else begin
                have_prev = 1;
            end
        endfunction

        function void check_result(t_out got);
            t_out e;
            if (pending.size() == 0) begin
                $error("unexpected result %h", got);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.out_x !== e.out_x) begin
                $error("out_x exp %h got %h", e.out_x, got.out_x); errors++;
            end
            if (got.out_y !== e.out_y) begin
                $error("out_y exp %h got %h", e.out_y, got.out_y); errors++;
            end
            if (got.out_z !== e.out_z) begin
                $error("out_z exp %h got %h", e.out_z, got.out_z); errors++;
            end
            if (got.point_valid !== e.point_valid) begin
                $error("point_valid exp %b got %b", e.point_valid, got.point_valid); errors++;
            end
            if (got.polygon_end !== e.polygon_end) begin
                $error("polygon_end exp %b got %b", e.polygon_end, got.polygon_end); errors++;
            end
        endfunction
    endclass

    logic       clk = 0;
    logic       rst_n = 0;
    logic       in_valid = 0;
    logic       in_ready;
    t_in        in_item = '0;
    logic       out_valid;
    logic       out_ready = 0;
    t_out       out_item;
    logic       cfg_we = 0;
    logic [2:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;

    clip_scoreboard sb = new();
    bit          stim_done = 0;
    int          vertices_sent = 0;

    always #6 clk = ~clk;

    polygon_plane_clip dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_in(in_item),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_out(out_item),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    // Results are taken and checked at the rising edge.
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) sb.check_result(out_item);
    end

    // Output side: random stalls, mostly short, sometimes long, with
    // stretches of full throughput.
    initial begin
        int g;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            g = $urandom_range(0, 99);
            if (g < 40) out_ready = 1;
            else if (g < 90) out_ready = ($urandom_range(0, 2) != 0);
            else begin
                out_ready = 0;
                repeat ($urandom_range(5, 60)) @(negedge clk);
                out_ready = 1;
            end
        end
    end

    // mostly short gaps, now and then a long one
    task automatic idle_gap();
        int g;
        g = $urandom_range(0, 99);
        if (g < 50) g = 0;
        else if (g < 92) g = $urandom_range(1, 4);
        else g = $urandom_range(20, 120);
        repeat (g) @(negedge clk);
    endtask

    // Holds valid until the item is taken; valid stays up across
    // back-to-back items, lowered only when a gap follows.
    task automatic send_vertex(logic [31:0] x, y, z, bit last);
        in_item.vertex_x = x; in_item.vertex_y = y; in_item.vertex_z = z;
        in_item.final_vertex = last;
        in_valid = 1;
        do @(posedge clk); while (!in_ready);
        sb.note_vertex(in_item);
        vertices_sent++;
        @(negedge clk);
        if ($urandom_range(0, 2) != 0) begin
            in_valid = 0;
            idle_gap();
        end
    endtask

    // Config writes happen only once the clipper has drained.
    task automatic drain();
        in_valid = 0;
        while (sb.pending.size() != 0) @(negedge clk);
        repeat (120) @(negedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        cfg_we = 1; cfg_index = idx; cfg_data = val;
        @(negedge clk);
        cfg_we = 0;
        sb.set_reg(idx, val);
    endtask

    function automatic logic [31:0] rnd_coord();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
            default: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
        endcase
    endfunction

    task automatic rnd_polygon(int n);
        for (int i = 0; i < n; i++)
            send_vertex(rnd_coord(), rnd_coord(), rnd_coord(), i == n - 1);
    endtask

    task automatic rnd_plane();
        write_reg(REG_NORMAL_X, 32'($signed($urandom_range(0, 32768)) - 16384));
        write_reg(REG_NORMAL_Y, 32'($signed($urandom_range(0, 32768)) - 16384));
        write_reg(REG_NORMAL_Z, 32'($signed($urandom_range(0, 32768)) - 16384));
        write_reg(REG_PLANE_OFFS, $urandom_range(0, 3) == 0 ? $urandom()
                  : 32'($signed($urandom_range(0, 400000)) - 200000));
        write_reg(REG_SIDE_TOL, $urandom_range(0, 3) == 0 ? $urandom() >> $urandom_range(0, 31)
                  : $urandom_range(0, 200));
    endtask

    initial begin
        repeat (8) @(negedge clk);
        rst_n = 1;

        // Directed, reset plane z-up: square straddling the plane, fully back,
        // fully front (empty marker), single vertex back and front, on-plane
        // vertices, extreme coordinates.
        send_vertex(32'h00010000, 32'h00010000, 32'h00010000, 0);
        send_vertex(32'hFFFF0000, 32'h00010000, 32'hFFFF0000, 0);
        send_vertex(32'hFFFF0000, 32'hFFFF0000, 32'hFFFF0000, 0);
        send_vertex(32'h00010000, 32'hFFFF0000, 32'h00010000, 1);
        send_vertex(32'h0, 32'h0, 32'hFFFF0000, 0);
        send_vertex(32'h00010000, 32'h0, 32'hFFFE0000, 1);
        send_vertex(32'h0, 32'h0, 32'h00050000, 0);
        send_vertex(32'h00010000, 32'h0, 32'h00060000, 1);
        send_vertex(32'h00030000, 32'h0, 32'hFFFD0000, 1);
        send_vertex(32'h00030000, 32'h0, 32'h00030000, 1);
        send_vertex(32'h0, 32'h0, 32'd40, 0);
        send_vertex(32'h0, 32'h0, 32'hFFFFFFC0, 1);
        send_vertex(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 0);
        send_vertex(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 0);
        send_vertex(32'hFFFFFFFF, 32'h0, 32'h7FFFFFFF, 1);
        drain();
        // extreme plane settings
        write_reg(REG_NORMAL_X, 32'hFFFFC000);
        write_reg(REG_NORMAL_Y, 32'h00004000);
        write_reg(REG_NORMAL_Z, 32'hFFFFC000);
        write_reg(REG_PLANE_OFFS, 32'h80000000);
        write_reg(REG_SIDE_TOL, 32'h7FFFFFFF);
        send_vertex(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 0);
        send_vertex(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 1);
        drain();
        write_reg(REG_SIDE_TOL, 32'h0);
        write_reg(REG_PLANE_OFFS, 32'h7FFFFFFF);
        send_vertex(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 0);
        send_vertex(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 0);
        send_vertex(32'h0, 32'h0, 32'h0, 1);
        drain();

        // Random polygons in phases, each under a fresh plane.
        while (vertices_sent < 210) begin
            rnd_plane();
            repeat ($urandom_range(3, 8)) rnd_polygon($urandom_range(1, 7));
            drain();
        end
        stim_done = 1;
    end

    initial begin
        wait (stim_done);
        repeat (200) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial begin
        #20ms;
        $display("Simulation FAILED");
        $finish;
    end
endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/ppc_pkg.sv
rtl/core/ppc_ctrl.sv
rtl/core/ppc_dpath.sv
rtl/core/polygon_plane_clip.sv
rtl/core/ppc_checker.sv
test/polygon_plane_clip_tb.sv
